[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/pkms_pkg.sv]
// Package with the types, register map and reset values of the pedal key macro sequencer.
package pkms_pkg;

	localparam int unsigned AddrW = 5;
	localparam int unsigned DataW = 32;
	localparam int unsigned RegIdxW = 3;

	localparam logic [RegIdxW-1:0] REG_IDLE_RELOAD    = 3'd0;
	localparam logic [RegIdxW-1:0] REG_IDLE_STEP      = 3'd1;
	localparam logic [RegIdxW-1:0] REG_DEBOUNCE_TICKS = 3'd2;
	localparam logic [RegIdxW-1:0] REG_FIRST_KEY      = 3'd3;
	localparam logic [RegIdxW-1:0] REG_SECOND_KEY     = 3'd4;
	localparam logic [RegIdxW-1:0] REG_SECOND_REPEATS = 3'd5;

	localparam logic [7:0] RST_IDLE_RELOAD    = 8'd0;
	localparam logic [7:0] RST_IDLE_STEP      = 8'd5;
	localparam logic [7:0] RST_DEBOUNCE_TICKS = 8'd10;
	localparam logic [7:0] RST_FIRST_KEY      = 8'h4e;
	localparam logic [7:0] RST_SECOND_KEY     = 8'h52;
	localparam logic [7:0] RST_SECOND_REPEATS = 8'd2;

	localparam logic [1:0] CODE_WAIT_PRESS   = 2'd0;
	localparam logic [1:0] CODE_FIRST_KEY    = 2'd1;
	localparam logic [1:0] CODE_SECOND_KEY   = 2'd2;
	localparam logic [1:0] CODE_WAIT_RELEASE = 2'd3;

	typedef enum logic [3:0] {
		PH_WAIT_PRESS   = 4'b0001,
		PH_FIRST_KEY    = 4'b0010,
		PH_SECOND_KEY   = 4'b0100,
		PH_WAIT_RELEASE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] idle_reload;
		logic [7:0] idle_step;
		logic [7:0] debounce_ticks;
		logic [7:0] first_key_code;
		logic [7:0] second_key_code;
		logic [7:0] second_key_repeats;
	} cfg_t;

	typedef struct packed {
		logic       report_valid;
		logic [7:0] key_code;
		logic [1:0] sequence_phase;
	} result_t;

	function automatic logic [1:0] phase_code(phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_WAIT_PRESS:   code = CODE_WAIT_PRESS;
			PH_FIRST_KEY:    code = CODE_FIRST_KEY;
			PH_SECOND_KEY:   code = CODE_SECOND_KEY;
			PH_WAIT_RELEASE: code = CODE_WAIT_RELEASE;
			default:         code = CODE_WAIT_PRESS;
		endcase
		return code;
	endfunction

endpackage

[rtl/pkms_core.sv]
// Sequencer state, timers and report logic, updated once for every accepted item.
module pkms_core (
	input  logic              clk,
	input  logic              arst_n,
	input  pkms_pkg::cfg_t    cfg,
	input  logic              accept,
	input  logic              tick,
	input  logic              button_pressed,
	input  logic              host_ready,
	output pkms_pkg::result_t result
);
	import pkms_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] held_key_q, held_key_d;
	logic       pending_q, pending_d;
	logic       forced_q, forced_d;
	logic [7:0] idle_cnt_q, idle_cnt_d;
	logic [7:0] repeats_q, repeats_d;
	logic [7:0] debounce_q, debounce_d;
	logic       sent;

	always_comb begin
		phase_d    = phase_q;
		held_key_d = held_key_q;
		pending_d  = pending_q;
		forced_d   = forced_q;
		idle_cnt_d = idle_cnt_q;
		repeats_d  = repeats_q;
		debounce_d = debounce_q;
		sent       = 1'b0;

		if (tick) begin
			if (debounce_q != 8'd0) begin
				debounce_d = debounce_q - 8'd1;
			end
			if (cfg.idle_reload != 8'd0) begin
				if (idle_cnt_q >= cfg.idle_step) begin
					idle_cnt_d = idle_cnt_q - cfg.idle_step;
				end else begin
					idle_cnt_d = cfg.idle_reload;
					forced_d   = 1'b1;
				end
			end
		end

		// The sequencer only advances once the previous report has gone out.
		if (!pending_q) begin
			unique case (phase_q)
				PH_WAIT_PRESS: begin
					if (debounce_d == 8'd0 && button_pressed) begin
						phase_d    = PH_FIRST_KEY;
						held_key_d = cfg.first_key_code;
						pending_d  = 1'b1;
					end
				end
				PH_FIRST_KEY: begin
					if (held_key_q != 8'd0) begin
						held_key_d = 8'd0;
					end else begin
						phase_d    = PH_SECOND_KEY;
						held_key_d = cfg.second_key_code;
						repeats_d  = (cfg.second_key_repeats == 8'd0) ? 8'd0
						           : cfg.second_key_repeats - 8'd1;
					end
					pending_d = 1'b1;
				end
				PH_SECOND_KEY: begin
					if (held_key_q != 8'd0) begin
						held_key_d = 8'd0;
						pending_d  = 1'b1;
					end else if (repeats_q != 8'd0) begin
						held_key_d = cfg.second_key_code;
						repeats_d  = repeats_q - 8'd1;
						pending_d  = 1'b1;
					end else begin
						phase_d = PH_WAIT_RELEASE;
					end
				end
				PH_WAIT_RELEASE: begin
					if (!button_pressed) begin
						phase_d    = PH_WAIT_PRESS;
						debounce_d = cfg.debounce_ticks;
					end
				end
				default: begin
					phase_d = PH_WAIT_PRESS;
				end
			endcase
		end

		if ((pending_d || forced_d) && host_ready) begin
			pending_d = 1'b0;
			forced_d  = 1'b0;
			sent      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_PRESS;
			held_key_q <= 8'd0;
			pending_q  <= 1'b0;
			forced_q   <= 1'b0;
			idle_cnt_q <= 8'd0;
			repeats_q  <= 8'd0;
			debounce_q <= 8'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			held_key_q <= held_key_d;
			pending_q  <= pending_d;
			forced_q   <= forced_d;
			idle_cnt_q <= idle_cnt_d;
			repeats_q  <= repeats_d;
			debounce_q <= debounce_d;
		end
	end

	assign result.report_valid   = sent;
	assign result.key_code       = held_key_d;
	assign result.sequence_phase = phase_code(phase_d);

endmodule

[rtl/pkms_out_buf.sv]
// Two-entry result buffer that decouples the input side from a stalled receiver.
module pkms_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pkms_pkg::result_t push_data,
	input  logic              pop,
	output logic              head_valid,
	output logic              full,
	output pkms_pkg::result_t head_data
);
	import pkms_pkg::*;

	result_t head_q, skid_q;
	logic    head_vld_q, skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				head_vld_q <= skid_vld_q || push;
				skid_vld_q <= 1'b0;
			end else if (push) begin
				if (head_vld_q) begin
					skid_vld_q <= 1'b1;
				end else begin
					head_vld_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers carry no reset; the valid flags qualify them.
	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			if (head_vld_q) begin
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

	assign head_valid = head_vld_q;
	assign full       = skid_vld_q;
	assign head_data  = head_q;

endmodule

[rtl/pedal_key_macro_sequencer_unit.sv]
// Top level of the pedal key macro sequencer: register port, sequencer core and result buffer.
//
// Each input item is one pass of the control loop: a timer tick flag, the pedal
// level and host readiness. Every accepted item yields exactly one result item:
// report_valid, the key currently held and the sequencer phase after that pass.
// Both channels move an item at a clock edge where valid is high and stall low.
// An item accepted at one edge has its result registered in the buffer, on the output
// in the next cycle when the output is free; throughput is one item per cycle while
// in_stall is low, set by the single registered pass of the sequencer core.
// A two-entry result buffer sits at the output: when the receiver stalls, the
// block still takes one more item, then raises in_stall until a result leaves.
// Stalled results hold their value.
// The six 8-bit registers sit on the APB-style port at byte addresses 0x00 to 0x14;
// pready is always high. The user must write them only while the block is idle;
// the block does not enforce it. Reset clears the sequencer, timers and buffer, and
// loads register defaults (idle rate 0, step 5, debounce 10, keys 0x4e, 0x52, two repeats).
`include "assert_macros.svh"

module pedal_key_macro_sequencer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pkms_pkg::AddrW-1:0]  paddr,
	input  logic [pkms_pkg::DataW-1:0]  pwdata,
	output logic [pkms_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        tick,
	input  logic                        button_pressed,
	input  logic                        host_ready,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        report_valid,
	output logic [7:0]                  key_code,
	output logic [1:0]                  sequence_phase
);
	import pkms_pkg::*;

	cfg_t               cfg_q;
	logic [RegIdxW-1:0] reg_idx;
	logic               cfg_write;
	logic               in_accept;
	logic               out_accept;
	logic               buf_full;
	logic               idle_phase;
	result_t            core_result;
	result_t            head_data;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[AddrW-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_reload        <= RST_IDLE_RELOAD;
			cfg_q.idle_step          <= RST_IDLE_STEP;
			cfg_q.debounce_ticks     <= RST_DEBOUNCE_TICKS;
			cfg_q.first_key_code     <= RST_FIRST_KEY;
			cfg_q.second_key_code    <= RST_SECOND_KEY;
			cfg_q.second_key_repeats <= RST_SECOND_REPEATS;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_IDLE_RELOAD:    cfg_q.idle_reload        <= pwdata[7:0];
				REG_IDLE_STEP:      cfg_q.idle_step          <= pwdata[7:0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks     <= pwdata[7:0];
				REG_FIRST_KEY:      cfg_q.first_key_code     <= pwdata[7:0];
				REG_SECOND_KEY:     cfg_q.second_key_code    <= pwdata[7:0];
				REG_SECOND_REPEATS: cfg_q.second_key_repeats <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IDLE_RELOAD:    prdata = {{(DataW-8){1'b0}}, cfg_q.idle_reload};
			REG_IDLE_STEP:      prdata = {{(DataW-8){1'b0}}, cfg_q.idle_step};
			REG_DEBOUNCE_TICKS: prdata = {{(DataW-8){1'b0}}, cfg_q.debounce_ticks};
			REG_FIRST_KEY:      prdata = {{(DataW-8){1'b0}}, cfg_q.first_key_code};
			REG_SECOND_KEY:     prdata = {{(DataW-8){1'b0}}, cfg_q.second_key_code};
			REG_SECOND_REPEATS: prdata = {{(DataW-8){1'b0}}, cfg_q.second_key_repeats};
			default:            prdata = '0;
		endcase
	end

	assign in_stall   = buf_full;
	assign in_accept  = in_valid && !in_stall;
	assign out_accept = out_valid && !out_stall;

	pkms_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.accept         (in_accept),
		.tick           (tick),
		.button_pressed (button_pressed),
		.host_ready     (host_ready),
		.result         (core_result)
	);

	pkms_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.push_data  (core_result),
		.pop        (out_accept),
		.head_valid (out_valid),
		.full       (buf_full),
		.head_data  (head_data)
	);

	assign report_valid   = head_data.report_valid;
	assign key_code       = head_data.key_code;
	assign sequence_phase = head_data.sequence_phase;

	assign idle_phase = (sequence_phase == CODE_WAIT_PRESS) ||
	                    (sequence_phase == CODE_WAIT_RELEASE);

	// The skid entry only fills behind a waiting head result.
	`ASSERT_IMPLY(a_skid_behind_head, in_stall, out_valid)
	// No key is held while waiting for a press or for the release.
	`ASSERT_IMPLY(a_idle_phase_no_key, out_valid && idle_phase, key_code == 8'd0)
	// An item taken into an empty buffer shows up at the output next cycle.
	`ASSERT_NEXT(a_item_reaches_output, in_accept && !out_valid, out_valid)

endmodule

[tb/pedal_key_macro_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for the pedal key macro sequencer unit: directed and random items against a predictor.

module pedal_key_macro_sequencer_unit_tb;
	import pkms_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned PHASE_ITEMS  = 125;
	localparam int unsigned NUM_PHASES   = 8;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              psel           = 1'b0;
	logic              penable        = 1'b0;
	logic              pwrite         = 1'b0;
	logic [AddrW-1:0]  paddr          = '0;
	logic [DataW-1:0]  pwdata         = '0;
	logic [DataW-1:0]  prdata;
	logic              pready;
	logic              in_valid       = 1'b0;
	logic              in_stall;
	logic              tick           = 1'b0;
	logic              button_pressed = 1'b0;
	logic              host_ready     = 1'b0;
	logic              out_valid;
	logic              out_stall      = 1'b0;
	logic              report_valid;
	logic [7:0]        key_code;
	logic [1:0]        sequence_phase;

	// Predictor copy of the registers and of the sequencer state.
	cfg_t pedal_cfg = '{
		idle_reload:        RST_IDLE_RELOAD,
		idle_step:          RST_IDLE_STEP,
		debounce_ticks:     RST_DEBOUNCE_TICKS,
		first_key_code:     RST_FIRST_KEY,
		second_key_code:    RST_SECOND_KEY,
		second_key_repeats: RST_SECOND_REPEATS
	};
	logic [1:0] seq_phase      = CODE_WAIT_PRESS;
	logic [7:0] held_key       = '0;
	logic       report_pending = 1'b0;
	logic       report_forced  = 1'b0;
	logic [7:0] idle_left      = '0;
	logic [7:0] repeats_left   = '0;
	logic [7:0] debounce_left  = '0;

	result_t pending_reports[$];
	int      errors      = 0;
	int      idle_cycles = 0;
	bit      quiet       = 1'b0;

	pedal_key_macro_sequencer_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.tick           (tick),
		.button_pressed (button_pressed),
		.host_ready     (host_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.report_valid   (report_valid),
		.key_code       (key_code),
		.sequence_phase (sequence_phase)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One pass of the control loop: ticks, then the sequencer, then the report.
	function automatic result_t advance_pedal_loop(logic t, logic btn, logic rdy);
		result_t r;
		r.report_valid = 1'b0;
		if (t) begin
			if (debounce_left != 0)
				debounce_left = debounce_left - 8'd1;
			if (pedal_cfg.idle_reload != 0) begin
				if (idle_left >= pedal_cfg.idle_step) begin
					idle_left = idle_left - pedal_cfg.idle_step;
				end else begin
					idle_left = pedal_cfg.idle_reload;
					report_forced = 1'b1;
				end
			end
		end
		if (!report_pending) begin
			unique case (seq_phase)
				CODE_WAIT_PRESS: begin
					if (debounce_left == 0 && btn) begin
						seq_phase = CODE_FIRST_KEY;
						held_key = pedal_cfg.first_key_code;
						report_pending = 1'b1;
					end
				end
				CODE_FIRST_KEY: begin
					if (held_key != 0) begin
						held_key = '0;
					end else begin
						seq_phase = CODE_SECOND_KEY;
						held_key = pedal_cfg.second_key_code;
						repeats_left = (pedal_cfg.second_key_repeats == 0) ? 8'd0 :
							pedal_cfg.second_key_repeats - 8'd1;
					end
					report_pending = 1'b1;
				end
				CODE_SECOND_KEY: begin
					if (held_key != 0) begin
						held_key = '0;
						report_pending = 1'b1;
					end else if (repeats_left != 0) begin
						held_key = pedal_cfg.second_key_code;
						repeats_left = repeats_left - 8'd1;
						report_pending = 1'b1;
					end else begin
						seq_phase = CODE_WAIT_RELEASE;
					end
				end
				default: begin
					if (!btn) begin
						seq_phase = CODE_WAIT_PRESS;
						debounce_left = pedal_cfg.debounce_ticks;
					end
				end
			endcase
		end
		if ((report_pending || report_forced) && rdy) begin
			report_pending = 1'b0;
			report_forced = 1'b0;
			r.report_valid = 1'b1;
		end
		r.key_code = held_key;
		r.sequence_phase = seq_phase;
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic send_item(logic t, logic btn, logic rdy);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		tick <= t;
		button_pressed <= btn;
		host_ready <= rdy;
		do
			@(posedge clk);
		while (in_stall);
		pending_reports.push_back(advance_pedal_loop(t, btn, rdy));
	endtask

	task automatic write_reg(logic [RegIdxW-1:0] idx, logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		unique case (idx)
			REG_IDLE_RELOAD:    pedal_cfg.idle_reload = value;
			REG_IDLE_STEP:      pedal_cfg.idle_step = value;
			REG_DEBOUNCE_TICKS: pedal_cfg.debounce_ticks = value;
			REG_FIRST_KEY:      pedal_cfg.first_key_code = value;
			REG_SECOND_KEY:     pedal_cfg.second_key_code = value;
			REG_SECOND_REPEATS: pedal_cfg.second_key_repeats = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(logic [7:0] rate, logic [7:0] step, logic [7:0] deb,
		logic [7:0] first_key, logic [7:0] second_key, logic [7:0] reps);
		drain_reports();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_IDLE_RELOAD, rate);
		write_reg(REG_IDLE_STEP, step);
		write_reg(REG_DEBOUNCE_TICKS, deb);
		write_reg(REG_FIRST_KEY, first_key);
		write_reg(REG_SECOND_KEY, second_key);
		write_reg(REG_SECOND_REPEATS, reps);
	endtask

	// A full press with the reset settings, a report held back by the host and debounce.
	task automatic test_default_macro();
		send_item(1'b0, 1'b0, 1'b1);
		send_item(1'b0, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b0);
		send_item(1'b0, 1'b1, 1'b1);
		repeat (5) send_item(1'b0, 1'b1, 1'b1);
		send_item(1'b0, 1'b0, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
	endtask

	// Zero idle step, zero first key, zero repeats, zero debounce, then forced reports.
	task automatic test_corner_settings();
		load_settings(8'd255, 8'd0, 8'd0, 8'd0, 8'hff, 8'd0);
		repeat (4) send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
		load_settings(8'd1, 8'd255, 8'd1, 8'h01, 8'h00, 8'd255);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b0, 1'b0, 1'b1);
		send_item(1'b1, 1'b0, 1'b1);
	endtask

	// Pedal presses of random length under several register settings.
	task automatic test_random_settings();
		int   tick_pct, ready_pct;
		bit   shaped;
		logic btn_level, t, btn, rdy;
		btn_level = 1'b0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			unique case (p)
				0: load_settings(RST_IDLE_RELOAD, RST_IDLE_STEP, RST_DEBOUNCE_TICKS,
					RST_FIRST_KEY, RST_SECOND_KEY, RST_SECOND_REPEATS);
				1: load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				2: load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				3: load_settings(8'd7, 8'd1, 8'd1, 8'h29, 8'h00, 8'd3);
				default: load_settings(8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 12)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 6)));
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			shaped = ($urandom_range(0, 4) != 0);
			tick_pct = $urandom_range(10, 90);
			ready_pct = $urandom_range(40, 100);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (shaped) begin
					if ($urandom_range(0, 9) == 0)
						btn_level = ~btn_level;
					btn = btn_level;
				end else begin
					btn = 1'($urandom_range(0, 1));
				end
				t = ($urandom_range(0, 99) < tick_pct);
				rdy = ($urandom_range(0, 99) < ready_pct);
				send_item(t, btn, rdy);
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		int run, len;
		forever begin
			out_stall <= 1'b0;
			run = $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			len = quiet ? 0 : pick_gap();
			if (len != 0) begin
				out_stall <= 1'b1;
				repeat (len) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("result with nothing expected, key_code", key_code, 8'd0);
			end else begin
				want = pending_reports.pop_front();
				if (report_valid !== want.report_valid)
					flag_mismatch("report_valid", 8'(report_valid),
						8'(want.report_valid));
				if (key_code !== want.key_code)
					flag_mismatch("key_code", key_code, want.key_code);
				if (sequence_phase !== want.sequence_phase)
					flag_mismatch("sequence_phase", 8'(sequence_phase),
						8'(want.sequence_phase));
			end
		end
	end

	// Ends the run when neither channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("pedal_key_macro_sequencer_unit_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_macro();
		test_corner_settings();
		test_random_settings();
		drain_reports();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("pedal_key_macro_sequencer_unit_tb: done, clean");
		else
			$display("pedal_key_macro_sequencer_unit_tb: done, errors");
		$finish;
	end

endmodule
